// ===== sv/bctd_pkg.sv =====
// Shared types and constants of the block cache tag directory.
// No dependencies; the front, back, top level and testbench import this package.
`timescale 1ns / 1ps

package bctd_pkg;

  // Field widths of the request and result transactions
  localparam int DEV_W  = 16;
  localparam int BLK_W  = 31;
  localparam int SLOT_W = 6;
  localparam int TAG_W  = DEV_W + BLK_W;

  // Directory size default and queue depth between the parts
  localparam int ENTRIES_DEF = 64;
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LIMIT_W    = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [0:0] {
    REG_ENTRY_LIMIT = 1'b0
  } reg_idx_t;

  typedef enum logic [0:0] {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    BK_MATCH  = 1'b0,
    BK_UPDATE = 1'b1
  } back_state_t;

  typedef struct packed {
    logic             kind;
    logic [DEV_W-1:0] device;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              fetch_needed;
    logic              write_through;
    logic              evicted;
    logic [DEV_W-1:0]  evicted_device;
    logic [BLK_W-1:0]  evicted_block;
  } rsp_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    op_t              op;
    logic [DEV_W-1:0] device;
    logic [BLK_W-1:0] block_number;
  } cmd_t;

endpackage

// ===== sv/bctd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module bctd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/bctd_fifo.sv =====
// Small synchronous queue with push/full and pop/empty sides.
// Depends on nothing; used between the parts of the tag directory.
`timescale 1ns / 1ps

module bctd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/bctd_front.sv =====
// Front part: request queue and request classification.
// Depends on bctd_pkg and bctd_fifo.
`timescale 1ns / 1ps

module bctd_front
  import bctd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  input  req_t in_data,
  output logic in_full,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_pop
);

  logic [$bits(req_t)-1:0] q_data;
  req_t                    head;
  logic                    q_empty;

  bctd_fifo #(
    .WIDTH($bits(req_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_req_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .wr_data(in_data),
    .full   (in_full),
    .pop    (cmd_pop),
    .rd_data(q_data),
    .empty  (q_empty)
  );

  assign head      = q_data;
  assign cmd_valid = !q_empty;

  always_comb begin
    cmd.op           = head.kind ? OP_WRITE : OP_READ;
    cmd.device       = head.device;
    cmd.block_number = head.block_number;
  end

endmodule

// ===== sv/bctd_back.sv =====
// Back part: parallel tag match, fill/replace decision and directory update.
// Depends on bctd_pkg and bctd_ram (copy of the tags for victim readout).
`timescale 1ns / 1ps

module bctd_back
  import bctd_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [$clog2(ENTRIES+1)-1:0] lim,
  input  logic                         cmd_valid,
  input  cmd_t                         cmd,
  output logic                         cmd_pop,
  input  logic                         rsp_full,
  output logic                         rsp_push,
  output rsp_t                         rsp
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  back_state_t state_r, state_nxt;

  // Tag cells: each compared in place against the request
  logic [DEV_W-1:0]   dev_r [ENTRIES];
  logic [BLK_W-1:0]   blk_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] match_nxt, match_r;

  logic [CNT_W-1:0]   used_r;
  logic [IDX_W-1:0]   oldest_r;
  cmd_t               cmd_r;
  logic [IDX_W-1:0]   miss_slot_r;
  logic               use_free_r;

  logic               start;
  logic               use_free;
  logic [IDX_W-1:0]   victim, miss_slot;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               evict;
  logic               do_fill;
  logic [CNT_W-1:0]   vic_p1;
  logic [IDX_W-1:0]   oldest_nxt;
  logic [TAG_W-1:0]   ev_tag;

  // Match stage decisions, from the current directory state
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && (dev_r[i] == cmd.device) &&
                     (blk_r[i] == cmd.block_number);
    end
    victim    = (CNT_W'(oldest_r) >= lim) ? '0 : oldest_r;
    use_free  = (used_r < lim);
    miss_slot = use_free ? used_r[IDX_W-1:0] : victim;
  end

  // Update stage: at most one cell can match, so an OR of indexes encodes it
  always_comb begin
    hit     = |match_r;
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
    evict      = !hit && !use_free_r && valid_r[miss_slot_r];
    vic_p1     = CNT_W'(miss_slot_r) + 1'b1;
    oldest_nxt = (vic_p1 >= lim) ? '0 : vic_p1[IDX_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    start     = 1'b0;
    cmd_pop   = 1'b0;
    rsp_push  = 1'b0;
    do_fill   = 1'b0;
    unique case (state_r)
      BK_MATCH: begin
        if (cmd_valid && !rsp_full) begin
          start     = 1'b1;
          cmd_pop   = 1'b1;
          state_nxt = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        rsp_push  = 1'b1;
        do_fill   = !hit;
        state_nxt = BK_MATCH;
      end
      default: state_nxt = BK_MATCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_MATCH;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      used_r   <= '0;
      oldest_r <= '0;
    end else if (do_fill) begin
      valid_r[miss_slot_r] <= 1'b1;
      if (use_free_r) begin
        used_r <= used_r + 1'b1;
      end else begin
        oldest_r <= oldest_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      match_r     <= match_nxt;
      cmd_r       <= cmd;
      miss_slot_r <= miss_slot;
      use_free_r  <= use_free;
    end
    if (do_fill) begin
      dev_r[miss_slot_r] <= cmd_r.device;
      blk_r[miss_slot_r] <= cmd_r.block_number;
    end
  end

  // Second copy of the tags, read at the victim slot during the match cycle
  bctd_ram #(
    .WIDTH(TAG_W),
    .DEPTH(ENTRIES)
  ) u_tag_ram (
    .clk    (clk),
    .wr_en  (do_fill),
    .wr_addr(miss_slot_r),
    .wr_data({cmd_r.device, cmd_r.block_number}),
    .rd_en  (start),
    .rd_addr(victim),
    .rd_data(ev_tag)
  );

  always_comb begin
    rsp.hit            = hit;
    rsp.slot           = SLOT_W'(hit ? hit_idx : miss_slot_r);
    rsp.fetch_needed   = !hit && (cmd_r.op == OP_READ);
    rsp.write_through  = (cmd_r.op == OP_WRITE);
    rsp.evicted        = evict;
    rsp.evicted_device = evict ? ev_tag[TAG_W-1:BLK_W] : '0;
    rsp.evicted_block  = evict ? ev_tag[BLK_W-1:0] : '0;
  end

endmodule

// ===== sv/block_cache_tag_directory_core.sv =====
// Top level of the block cache tag directory: config register, front, back, result queue.
// Depends on bctd_pkg, bctd_front, bctd_back, bctd_fifo and bctd_ram.
`timescale 1ns / 1ps

// Fully associative tag directory for a disk block cache with FIFO replacement.
// Each request transaction (read or write, device, block number) is matched
// against every valid entry at once. A hit reports the slot. A miss takes the
// next free slot while fewer than entry_limit slots are in use, else replaces
// the oldest inserted entry and reports its tag. A read miss raises
// fetch_needed; every write raises write_through; entries stay clean so no
// write-back is ever requested. Each request passes through the back part in
// BK_MATCH (parallel compare and victim tag read from RAM) and then BK_UPDATE
// (update and result); the back takes no new request until it has finished
// the last one, and starts one only while the result queue has a free slot.
// An accepted request waits in the request queue until the back takes it in
// BK_MATCH, and its result is pushed into the result queue from BK_UPDATE. Both
// sides are two-deep queues, so pushes are taken while an unread result waits.
// There is no clearing pass after reset. entry_limit (byte address 0, reset
// 64) is clamped to 1..ENTRIES and should be written only while the block is
// idle.

module block_cache_tag_directory_core
  import bctd_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_push,
  input  req_t                  in_data,
  output logic                  in_full,
  // result channel
  input  logic                  out_pop,
  output rsp_t                  out_data,
  output logic                  out_empty,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [LIMIT_W-1:0] entry_limit_r;
  logic               cfg_wr;
  logic               sel_limit;
  logic [CMP_W-1:0]   lim_wide;
  logic [CNT_W-1:0]   lim;

  logic               cmd_valid, cmd_pop;
  cmd_t               cmd;
  logic               rsp_push, rsp_full;
  rsp_t               rsp;

  // APB: no wait states; register index is the address above the byte lane
  assign cfg_pready = 1'b1;
  assign sel_limit  = (cfg_paddr[CFG_ADDR_W-1:2] == REG_ENTRY_LIMIT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = sel_limit ? CFG_DATA_W'(entry_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_limit_r <= LIMIT_RESET;
    end else if (cfg_wr && sel_limit) begin
      entry_limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  // Effective limit: zero acts as one, anything above the directory size saturates
  always_comb begin
    lim_wide = CMP_W'(entry_limit_r);
    if (lim_wide == '0) begin
      lim_wide = CMP_W'(1);
    end else if (lim_wide > CMP_W'(ENTRIES)) begin
      lim_wide = CMP_W'(ENTRIES);
    end
    lim = lim_wide[CNT_W-1:0];
  end

  bctd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  bctd_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .lim      (lim),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .rsp_full (rsp_full),
    .rsp_push (rsp_push),
    .rsp      (rsp)
  );

  // Result queue: the back only starts a transaction when a slot is free here
  bctd_fifo #(
    .WIDTH($bits(rsp_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_rsp_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (rsp_push),
    .wr_data(rsp),
    .full   (rsp_full),
    .pop    (out_pop),
    .rd_data(out_data),
    .empty  (out_empty)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for block_cache_tag_directory_core.
// Directed table, then random phases at several entry limits, against a shadow directory.
// Depends on bctd_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
  import bctd_pkg::*;

  localparam int ENTRIES     = ENTRIES_DEF;
  localparam int IDLE_LIMIT  = 2000;  // cycles without any transaction before giving up
  localparam int TAG_POOL    = 80;    // recently requested tags kept for reuse
  localparam int PHASE_ITEMS = 90;
  localparam int NUM_PHASES  = 9;
  localparam logic [LIMIT_W-1:0] PHASE_LIMITS [8] =
    '{7'd3, 7'd64, 7'd1, 7'd0, 7'd127, 7'd8, 7'd2, 7'd40};

  typedef struct {
    bit                 is_cfg;
    logic [LIMIT_W-1:0] limit;
    req_t               req;
    bit                 typed;
    rsp_t               rsp;
  } dir_step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  req_t                  in_data;
  logic                  in_full;
  logic                  out_pop;
  rsp_t                  out_data;
  logic                  out_empty;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  block_cache_tag_directory_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_data     (in_data),
    .in_full     (in_full),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .out_empty   (out_empty),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow copy of the directory state
  logic               dir_valid [ENTRIES];
  logic [DEV_W-1:0]   dir_dev   [ENTRIES];
  logic [BLK_W-1:0]   dir_blk   [ENTRIES];
  int unsigned        dir_used;
  int unsigned        dir_oldest;
  logic [LIMIT_W-1:0] limit_shadow;

  rsp_t      pending_rsp [$];  // expected results, oldest first
  req_t      tag_pool    [$];
  dir_step_t dir_steps   [$];
  int        fail_count;
  bit        no_idle;          // burst phases: neither side idles

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // entry_limit clamped to 1..ENTRIES
  function automatic int unsigned active_limit();
    if (limit_shadow == '0) return 1;
    if (limit_shadow > ENTRIES) return ENTRIES;
    return limit_shadow;
  endfunction

  // Parallel tag match, then free-slot fill or FIFO replacement; updates the shadow.
  function automatic rsp_t predict_lookup(req_t r);
    rsp_t        res;
    int unsigned lim;
    int unsigned victim;
    int unsigned slot;
    bit          hit;
    int          i;
    res  = '0;
    hit  = 1'b0;
    slot = 0;
    lim  = active_limit();
    for (i = 0; i < ENTRIES; i++) begin
      if (!hit && dir_valid[i] && dir_dev[i] == r.device && dir_blk[i] == r.block_number) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    if (!hit) begin
      if (dir_used < lim) begin
        slot = dir_used;
        dir_used++;
      end else begin
        // pointer left beyond a lowered limit restarts at slot 0
        victim = (dir_oldest >= lim) ? 0 : dir_oldest;
        slot   = victim;
        if (dir_valid[slot]) begin
          res.evicted        = 1'b1;
          res.evicted_device = dir_dev[slot];
          res.evicted_block  = dir_blk[slot];
        end
        victim++;
        dir_oldest = (victim >= lim) ? 0 : victim;
      end
      dir_valid[slot] = 1'b1;
      dir_dev[slot]   = r.device;
      dir_blk[slot]   = r.block_number;
    end
    res.hit           = hit;
    res.slot          = SLOT_W'(slot);
    res.fetch_needed  = !hit && (r.kind == OP_READ);
    res.write_through = (r.kind == OP_WRITE);
    return res;
  endfunction

  function automatic string fmt_rsp(rsp_t r);
    return $sformatf("hit=%0b slot=%0d fetch=%0b wt=%0b ev=%0b ev_dev=%h ev_blk=%h",
                     r.hit, r.slot, r.fetch_needed, r.write_through, r.evicted,
                     r.evicted_device, r.evicted_block);
  endfunction

  function automatic rsp_t mk_rsp(bit hit, int slot, bit fetch, bit wt, bit ev,
                                  logic [DEV_W-1:0] edev, logic [BLK_W-1:0] eblk);
    rsp_t r;
    r.hit            = hit;
    r.slot           = SLOT_W'(slot);
    r.fetch_needed   = fetch;
    r.write_through  = wt;
    r.evicted        = ev;
    r.evicted_device = edev;
    r.evicted_block  = eblk;
    return r;
  endfunction

  function automatic dir_step_t req_row(op_t kind, logic [DEV_W-1:0] dev,
                                        logic [BLK_W-1:0] blk);
    dir_step_t s;
    s.is_cfg = 1'b0;
    s.limit  = '0;
    s.req    = '{kind: kind, device: dev, block_number: blk};
    s.typed  = 1'b0;
    s.rsp    = '0;
    return s;
  endfunction

  function automatic dir_step_t exp_row(op_t kind, logic [DEV_W-1:0] dev,
                                        logic [BLK_W-1:0] blk, rsp_t rsp);
    dir_step_t s;
    s       = req_row(kind, dev, blk);
    s.typed = 1'b1;
    s.rsp   = rsp;
    return s;
  endfunction

  function automatic dir_step_t cfg_row(logic [LIMIT_W-1:0] limit);
    dir_step_t s;
    s        = req_row(OP_READ, '0, '0);
    s.is_cfg = 1'b1;
    s.limit  = limit;
    return s;
  endfunction

  // Most often reuse of recent tags (hits, thrashing), else tiny tag space or fully random.
  function automatic req_t random_request();
    req_t r;
    req_t t;
    int   pick;
    pick   = $urandom_range(0, 99);
    r.kind = 1'($urandom_range(0, 1));
    if (pick < 45 && tag_pool.size() != 0) begin
      t              = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
      r.device       = t.device;
      r.block_number = t.block_number;
    end else if (pick < 70) begin
      r.device       = DEV_W'($urandom_range(0, 3));
      r.block_number = BLK_W'($urandom_range(0, 15));
    end else begin
      r.device       = DEV_W'($urandom);
      r.block_number = BLK_W'($urandom);
    end
    tag_pool.push_back(r);
    if (tag_pool.size() > TAG_POOL) void'(tag_pool.pop_front());
    return r;
  endfunction

  task automatic check_result(rsp_t got);
    rsp_t  want;
    string diffs;
    if (pending_rsp.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("ERROR %0t: unexpected result %s", $time, fmt_rsp(got));
      return;
    end
    want  = pending_rsp.pop_front();
    diffs = "";
    if (got.hit !== want.hit)                       diffs = {diffs, " hit"};
    if (got.slot !== want.slot)                     diffs = {diffs, " slot"};
    if (got.fetch_needed !== want.fetch_needed)     diffs = {diffs, " fetch_needed"};
    if (got.write_through !== want.write_through)   diffs = {diffs, " write_through"};
    if (got.evicted !== want.evicted)               diffs = {diffs, " evicted"};
    if (got.evicted_device !== want.evicted_device) diffs = {diffs, " evicted_device"};
    if (got.evicted_block !== want.evicted_block)   diffs = {diffs, " evicted_block"};
    if (diffs != "") begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("ERROR %0t: mismatch on%s", $time, diffs);
        $display("  expected %s", fmt_rsp(want));
        $display("  actual   %s", fmt_rsp(got));
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
    int   gap;
    rsp_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push = 1'b1;
    in_data = r;
    do @(posedge clk); while (in_full !== 1'b0);
    pred = predict_lookup(r);
    pending_rsp.push_back(typed ? typed_rsp : pred);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_push = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  // APB write of entry_limit (junk in the upper bits), then read back.
  task automatic write_entry_limit(logic [LIMIT_W-1:0] val);
    logic [CFG_DATA_W-1:0] word;
    word                = $urandom;
    word[LIMIT_W-1:0]   = val;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CFG_ADDR_W'(int'(REG_ENTRY_LIMIT) * 4);
    cfg_pwdata  = word;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    limit_shadow = val;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== CFG_DATA_W'(val)) begin
      fail_count++;
      if (fail_count <= 10)
        $display("ERROR %0t: entry_limit readback expected %h, actual %h",
                 $time, CFG_DATA_W'(val), cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Result side: random stall, then pop until one transaction is taken.
  initial begin
    int stall;
    out_pop = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_pop = 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
      check_result(out_data);
      @(negedge clk);
    end
  end

  // Watchdog: too long without any transaction on any port
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_psel) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    dir_step_t s;
    int        ph;
    int        k;
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    fail_count  = 0;
    no_idle     = 1'b0;
    dir_used    = 0;
    dir_oldest  = 0;
    limit_shadow = LIMIT_RESET;
    for (k = 0; k < ENTRIES; k++) begin
      dir_valid[k] = 1'b0;
      dir_dev[k]   = '0;
      dir_blk[k]   = '0;
    end

    // Reset-limit fill, extremes of both tag fields, hits for read and write
    dir_steps.push_back(exp_row(OP_READ, 16'h0000, 31'h0, mk_rsp(0, 0, 1, 0, 0, 0, 0)));
    dir_steps.push_back(exp_row(OP_WRITE, 16'hFFFF, 31'h7FFFFFFF,
                                mk_rsp(0, 1, 0, 1, 0, 0, 0)));
    dir_steps.push_back(exp_row(OP_READ, 16'hFFFF, 31'h7FFFFFFF,
                                mk_rsp(1, 1, 0, 0, 0, 0, 0)));
    dir_steps.push_back(exp_row(OP_WRITE, 16'h0000, 31'h0, mk_rsp(1, 0, 0, 1, 0, 0, 0)));
    dir_steps.push_back(exp_row(OP_READ, 16'h0000, 31'h7FFFFFFF,
                                mk_rsp(0, 2, 1, 0, 0, 0, 0)));
    dir_steps.push_back(exp_row(OP_READ, 16'hFFFF, 31'h0, mk_rsp(0, 3, 1, 0, 0, 0, 0)));
    // Lowered limit: slots above it still hit, replacement cycles over slots 0 and 1
    dir_steps.push_back(cfg_row(7'd2));
    dir_steps.push_back(exp_row(OP_READ, 16'h0000, 31'h7FFFFFFF,
                                mk_rsp(1, 2, 0, 0, 0, 0, 0)));
    dir_steps.push_back(exp_row(OP_READ, 16'h1234, 31'h5, mk_rsp(0, 0, 1, 0, 1, 0, 0)));
    dir_steps.push_back(exp_row(OP_WRITE, 16'h1234, 31'h6,
                                mk_rsp(0, 1, 0, 1, 1, 16'hFFFF, 31'h7FFFFFFF)));
    dir_steps.push_back(exp_row(OP_READ, 16'h1234, 31'h5, mk_rsp(1, 0, 0, 0, 0, 0, 0)));
    // Zero limit acts as one entry
    dir_steps.push_back(cfg_row(7'd0));
    dir_steps.push_back(exp_row(OP_READ, 16'hAAAA, 31'h55555555,
                                mk_rsp(0, 0, 1, 0, 1, 16'h1234, 31'h5)));
    dir_steps.push_back(exp_row(OP_WRITE, 16'h5555, 31'h2AAAAAAA,
                                mk_rsp(0, 0, 0, 1, 1, 16'hAAAA, 31'h55555555)));
    // Over-range limit clamps to the directory size; free slots are taken again
    dir_steps.push_back(cfg_row(7'd127));
    dir_steps.push_back(exp_row(OP_READ, 16'h0000, 31'h1, mk_rsp(0, 4, 1, 0, 0, 0, 0)));
    dir_steps.push_back(req_row(OP_WRITE, 16'h1234, 31'h6));
    // Advance the replacement pointer, then lower the limit below it
    dir_steps.push_back(cfg_row(7'd5));
    for (k = 0; k < 4; k++) dir_steps.push_back(req_row(OP_READ, DEV_W'(16'h00F0 + k), BLK_W'(k)));
    dir_steps.push_back(cfg_row(7'd2));
    dir_steps.push_back(req_row(OP_WRITE, 16'h8000, 31'h40000000));
    dir_steps.push_back(req_row(OP_READ, 16'h0000, 31'h7FFFFFFF));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_steps[i]) begin
      s = dir_steps[i];
      if (s.is_cfg) begin
        wait_drained();
        write_entry_limit(s.limit);
      end else begin
        send_request(s.req, s.typed, s.rsp);
      end
    end

    // Random phases; every third one runs with no idling on either side
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      write_entry_limit(ph < 8 ? PHASE_LIMITS[ph] : LIMIT_W'($urandom_range(1, ENTRIES)));
      no_idle = (ph % 3 == 1);
      repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
    end

    wait_drained();
    no_idle = 1'b0;
    repeat (8) @(negedge clk);
    if (pending_rsp.size() != 0) begin
      fail_count++;
      $display("ERROR %0t: %0d results never arrived", $time, pending_rsp.size());
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bctd_pkg.sv
sv/bctd_ram.sv
sv/bctd_fifo.sv
sv/bctd_front.sv
sv/bctd_back.sv
sv/block_cache_tag_directory_core.sv
verif/tb.sv
